>>> design/kmc_pkg.sv
// shared constants, types and helpers for the k-mer mismatch candidate filter
package kmc_pkg;

    localparam int KMER_LEN  = 32;
    localparam int QUARTERS  = 4;
    localparam int QMAX      = (KMER_LEN + QUARTERS - 1) / QUARTERS;
    localparam int QCW       = $clog2(QMAX + 1);
    localparam int TW        = $clog2(QUARTERS * QMAX + 1);
    localparam int IDXW      = $clog2(KMER_LEN);
    localparam int TOTAL_MAX = KMER_LEN / 3;
    localparam int END_MAX   = KMER_LEN / 6;

    typedef logic [QCW-1:0] t_qcount;

    typedef struct packed {
        logic [KMER_LEN-1:0] mask;
        logic [31:0]         edge_id;
        logic [31:0]         offset;
    } t_pair;

    typedef struct packed {
        logic valid;
        logic keep;
    } t_load;

    // first base of quarter q: smallest i with (4*i)/KMER_LEN == q
    function automatic int qstart(input int q);
        return (q * KMER_LEN + QUARTERS - 1) / QUARTERS;
    endfunction

    function automatic int qsize(input int q);
        return qstart(q + 1) - qstart(q);
    endfunction

endpackage

>>> design/kmc_lane.sv
// one quarter lane: base compare and mismatch count over up to QMAX bases
module kmc_lane
    import kmc_pkg::*;
(
    input  logic [2*QMAX-1:0] i_src_bases,
    input  logic [2*QMAX-1:0] i_tgt_bases,
    input  logic [QMAX-1:0]   i_base_en,
    output logic [QMAX-1:0]   o_diff,
    output t_qcount           o_count
);

    always_comb begin
        o_count = '0;
        for (int b = 0; b < QMAX; b++) begin
            o_diff[b] = i_base_en[b] &&
                        (i_src_bases[2*b +: 2] != i_tgt_bases[2*b +: 2]);
            o_count   = o_count + QCW'(o_diff[b]);
        end
    end

endmodule

>>> design/kmc_merge.sv
// merges quarter counts into the keep/drop decision for one pair
module kmc_merge
    import kmc_pkg::*;
(
    input  t_qcount i_counts [QUARTERS],
    input  logic    i_ok,
    output logic    o_keep
);

    logic [TW-1:0] total;

    always_comb begin
        total = '0;
        for (int q = 0; q < QUARTERS; q++) begin
            total = total + TW'(i_counts[q]);
        end
        o_keep = i_ok && (total != '0) && (total <= TW'(TOTAL_MAX)) &&
                 (i_counts[0] <= QCW'(END_MAX)) &&
                 (i_counts[QUARTERS-1] <= QCW'(END_MAX));
    end

endmodule

>>> design/kmc_emit.sv
// serial emitter: one candidate per cycle, lowest mismatching base first
module kmc_emit
    import kmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_load       i_load,
    input  t_pair       i_pair,
    output logic        o_free,
    output logic        o_result_valid,
    output logic [31:0] o_mismatch_edge,
    output logic [31:0] o_mismatch_position,
    output logic        o_last_of_run
);

    logic [KMER_LEN-1:0] r_mask, n_mask;
    logic [31:0]         r_edge;
    logic [31:0]         r_offset;
    logic                r_valid;
    logic [31:0]         r_out_edge;
    logic [31:0]         r_out_pos;
    logic                r_out_last;
    logic [IDXW-1:0]     idx;
    logic [KMER_LEN-1:0] rest;
    logic                load;

    // lowest set bit wins
    always_comb begin
        idx = '0;
        for (int i = KMER_LEN - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = IDXW'(i);
            end
        end
    end

    assign rest   = r_mask & (r_mask - KMER_LEN'(1));
    assign o_free = (rest == '0);
    assign load   = o_free && i_load.valid;

    always_comb begin
        if (load) begin
            n_mask = i_load.keep ? i_pair.mask : '0;
        end else begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask  <= n_mask;
            r_valid <= (r_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_edge   <= i_pair.edge_id;
            r_offset <= i_pair.offset;
        end
        r_out_edge <= r_edge;
        r_out_pos  <= r_offset + 32'(idx);
        r_out_last <= (rest == '0);
    end

    assign o_result_valid      = r_valid;
    assign o_mismatch_edge     = r_out_edge;
    assign o_mismatch_position = r_out_pos;
    assign o_last_of_run       = r_out_last;

    a_mask_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) <= TOTAL_MAX)
        else $error("emitter holds more mismatches than the total limit");

    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out_last |=> r_valid)
        else $error("candidate run broken before its last transfer");

    a_run_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out_last |=> r_out_edge == $past(r_out_edge))
        else $error("edge id changed inside a candidate run");

endmodule

>>> design/kmer_mismatch_candidate_filter.sv
// top level: quarter lanes, input stage, merge decision and serial emitter
//
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+-------------------------
// pair in  | i_source_kmer i_target_kmer i_target_in_graph  | start high, busy low
//          | i_edge_id i_edge_offset                        |
// cand out | o_mismatch_edge o_mismatch_position            | o_result_valid, one cycle
//          | o_last_of_run                                  |
//
// a transfer is registered after the lane compare; once the emitter takes the pair,
// its first candidate passes the emitter mask register and then the output registers
// the emitter works through a pair with n candidates (n <= KMER_LEN/3) one at a time;
// rejected pairs stream one per cycle while no kept pair holds the emitter
// busy rises only when the input stage holds a pair the emitter cannot take yet
// reset (synchronous, low) empties the input stage and the emitter
// results cannot be held off by the receiver
module kmer_mismatch_candidate_filter
    import kmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_source_kmer,
    input  logic [63:0] i_target_kmer,
    input  logic        i_target_in_graph,
    input  logic [31:0] i_edge_id,
    input  logic [39:0] i_edge_offset,
    output logic        o_result_valid,
    output logic [31:0] o_mismatch_edge,
    output logic [31:0] o_mismatch_position,
    output logic        o_last_of_run
);

    logic [QMAX-1:0]     lane_diff  [QUARTERS];
    t_qcount             lane_count [QUARTERS];
    logic [KMER_LEN-1:0] diff_mask;

    logic                r_s1_valid;
    logic [KMER_LEN-1:0] r_s1_mask;
    t_qcount             r_s1_count [QUARTERS];
    logic [31:0]         r_s1_edge;
    logic [31:0]         r_s1_offset;
    logic                r_s1_ok;
    logic                n_s1_valid;

    logic                accept;
    logic                take;
    logic                emit_free;
    logic                keep;
    t_load               load;
    t_pair               pair;

    for (genvar q = 0; q < QUARTERS; q++) begin : g_lane
        kmc_lane u_lane (
            .i_src_bases ((2*QMAX)'(i_source_kmer >> (2 * qstart(q)))),
            .i_tgt_bases ((2*QMAX)'(i_target_kmer >> (2 * qstart(q)))),
            .i_base_en   (QMAX'((1 << qsize(q)) - 1)),
            .o_diff      (lane_diff[q]),
            .o_count     (lane_count[q])
        );
    end

    // place each lane's bits back at its base positions
    always_comb begin
        logic [KMER_LEN+QMAX-1:0] acc;
        acc = '0;
        for (int q = 0; q < QUARTERS; q++) begin
            acc = acc | ((KMER_LEN + QMAX)'(lane_diff[q]) << qstart(q));
        end
        diff_mask = acc[KMER_LEN-1:0];
    end

    assign take       = r_s1_valid && emit_free;
    assign busy       = r_s1_valid && !emit_free;
    assign accept     = start && !busy;
    assign n_s1_valid = accept || (r_s1_valid && !take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mask   <= diff_mask;
            r_s1_count  <= lane_count;
            r_s1_edge   <= i_edge_id;
            r_s1_offset <= i_edge_offset[31:0];
            // large offsets yield nothing
            r_s1_ok     <= i_target_in_graph && (i_edge_offset[39:32] == '0);
        end
    end

    kmc_merge u_merge (
        .i_counts (r_s1_count),
        .i_ok     (r_s1_ok),
        .o_keep   (keep)
    );

    assign load.valid   = r_s1_valid;
    assign load.keep    = keep;
    assign pair.mask    = r_s1_mask;
    assign pair.edge_id = r_s1_edge;
    assign pair.offset  = r_s1_offset;

    kmc_emit u_emit (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (load),
        .i_pair              (pair),
        .o_free              (emit_free),
        .o_result_valid      (o_result_valid),
        .o_mismatch_edge     (o_mismatch_edge),
        .o_mismatch_position (o_mismatch_position),
        .o_last_of_run       (o_last_of_run)
    );

    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pair not held in the input stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> r_s1_valid && $stable(r_s1_mask))
        else $error("stalled pair changed in the input stage");

endmodule

>>> tb/kmer_mismatch_candidate_filter_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the k-mer mismatch candidate filter
module kmer_mismatch_candidate_filter_test;
    import kmc_pkg::*;

    localparam int NUM_RANDOM   = 180;
    localparam int NUM_DIRECTED = 19;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    // first base of the second and of the last quarter
    localparam int Q1_LO = (KMER_LEN + QUARTERS - 1) / QUARTERS;
    localparam int Q3_LO = (3 * KMER_LEN + QUARTERS - 1) / QUARTERS;

    typedef struct {
        logic [63:0] src_kmer;
        logic [63:0] tgt_kmer;
        logic        in_graph;
        logic [31:0] edge_id;
        logic [39:0] offset;
    } kmer_pair_t;

    typedef struct {
        logic [31:0] edge_id;
        logic [31:0] position;
        logic        last;
    } candidate_t;

    // target = source with the masked bases changed by flip_code
    typedef struct packed {
        logic [63:0]         src_kmer;
        logic [KMER_LEN-1:0] flip_mask;
        logic [1:0]          flip_code;
        logic                in_graph;
        logic [31:0]         edge_id;
        logic [39:0]         offset;
        logic                typed;
        logic                typed_hit;
        logic [31:0]         typed_position;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // target absent
        '{64'h0, 32'h0000_0001, 2'd3, 1'b0, 32'h1234_5678, 40'd100, 1'b1, 1'b0, 32'd0},
        // identical k-mers, all zeros and all ones
        '{64'h0, 32'h0, 2'd1, 1'b1, 32'h0, 40'd0, 1'b1, 1'b0, 32'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 2'd1, 1'b1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF,
          1'b1, 1'b0, 32'd0},
        // lowest base, zero edge and offset
        '{64'h0, 32'h0000_0001, 2'd1, 1'b1, 32'h0, 40'd0, 1'b1, 1'b1, 32'd0},
        // highest base, position wraps
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 2'd2, 1'b1, 32'hFFFF_FFFF,
          40'h00_FFFF_FFFF, 1'b1, 1'b1, 32'd30},
        // offset past 32 bits
        '{64'h0123_4567_89AB_CDEF, 32'h0000_1000, 2'd3, 1'b1, 32'hA5A5_5A5A,
          40'h01_0000_0000, 1'b1, 1'b0, 32'd0},
        '{64'h0123_4567_89AB_CDEF, 32'h0001_0000, 2'd1, 1'b1, 32'h5A5A_A5A5,
          40'hFF_FFFF_FFFF, 1'b1, 1'b0, 32'd0},
        // ten mismatches spread over all quarters
        '{64'h0F0F_F0F0_3C3C_C3C3, 32'h8191_9181, 2'd3, 1'b1, 32'h0000_0042, 40'd1000,
          1'b0, 1'b0, 32'd0},
        // eleven mismatches
        '{64'h0F0F_F0F0_3C3C_C3C3, 32'h800F_0F81, 2'd2, 1'b1, 32'h0000_0043, 40'd1000,
          1'b1, 1'b0, 32'd0},
        // first quarter crowded, last quarter crowded
        '{64'h0, 32'h0000_003F, 2'd1, 1'b1, 32'h0000_0044, 40'd7, 1'b1, 1'b0, 32'd0},
        '{64'h0, 32'hFC00_0000, 2'd1, 1'b1, 32'h0000_0045, 40'd7, 1'b1, 1'b0, 32'd0},
        // both end quarters at the limit
        '{64'h5555_5555_5555_5555, 32'hF800_001F, 2'd3, 1'b1, 32'h0000_0046, 40'd77,
          1'b0, 1'b0, 32'd0},
        // every base differs
        '{64'h0, 32'hFFFF_FFFF, 2'd3, 1'b1, 32'h0000_0047, 40'd0, 1'b1, 1'b0, 32'd0},
        // ten in the middle quarters
        '{64'hAAAA_AAAA_AAAA_AAAA, 32'h001F_1F00, 2'd1, 1'b1, 32'hDEAD_BEEF, 40'd123456,
          1'b0, 1'b0, 32'd0},
        // passing pattern but target absent
        '{64'h0, 32'h0000_1000, 2'd2, 1'b0, 32'h0000_0048, 40'd9, 1'b1, 1'b0, 32'd0},
        // wrap across 2^32 with several candidates, then a single base at offset 2^31
        '{64'h3333_CCCC_3333_CCCC, 32'h8000_0101, 2'd2, 1'b1, 32'h8000_0001,
          40'h00_FFFF_FFF8, 1'b0, 1'b0, 32'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_1000, 2'd2, 1'b1, 32'h7FFF_FFFF,
          40'h00_8000_0000, 1'b1, 1'b1, 32'h8000_000C},
        // single base in the last quarter
        '{64'h0, 32'h0100_0000, 2'd1, 1'b1, 32'h0000_0049, 40'd5, 1'b1, 1'b1, 32'd29},
        // first quarter at the limit alone
        '{64'hFFFF_0000_FFFF_0000, 32'h0000_001F, 2'd2, 1'b1, 32'h0000_004A, 40'd3,
          1'b0, 1'b0, 32'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_source_kmer = '0;
    logic [63:0] i_target_kmer = '0;
    logic        i_target_in_graph = 1'b0;
    logic [31:0] i_edge_id = '0;
    logic [39:0] i_edge_offset = '0;
    logic        o_result_valid;
    logic [31:0] o_mismatch_edge;
    logic [31:0] o_mismatch_position;
    logic        o_last_of_run;

    candidate_t pending_candidates[$];
    int         bad_candidates = 0;

    kmer_mismatch_candidate_filter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_source_kmer       (i_source_kmer),
        .i_target_kmer       (i_target_kmer),
        .i_target_in_graph   (i_target_in_graph),
        .i_edge_id           (i_edge_id),
        .i_edge_offset       (i_edge_offset),
        .o_result_valid      (o_result_valid),
        .o_mismatch_edge     (o_mismatch_edge),
        .o_mismatch_position (o_mismatch_position),
        .o_last_of_run       (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // expected candidates of one pair, appended in base order
    function automatic void predict_candidates(input kmer_pair_t p);
        logic [KMER_LEN-1:0] differs;
        int                  total;
        int                  qcount [QUARTERS];
        int                  emitted;
        candidate_t          c;
        total = 0;
        emitted = 0;
        foreach (qcount[q]) qcount[q] = 0;
        for (int i = 0; i < KMER_LEN; i++) begin
            differs[i] = p.src_kmer[2*i +: 2] != p.tgt_kmer[2*i +: 2];
            if (differs[i]) begin
                total++;
                qcount[(i * QUARTERS) / KMER_LEN]++;
            end
        end
        if (!p.in_graph || total == 0 || total > TOTAL_MAX) return;
        if (qcount[0] > END_MAX || qcount[QUARTERS-1] > END_MAX) return;
        if (p.offset[39:32] != 8'h00) return;
        for (int i = 0; i < KMER_LEN; i++) begin
            if (differs[i]) begin
                emitted++;
                c.edge_id = p.edge_id;
                c.position = p.offset[31:0] + 32'(i);
                c.last = (emitted == total);
                pending_candidates.push_back(c);
            end
        end
    endfunction

    // code 0 picks a random nonzero change per base
    function automatic logic [63:0] flip_bases(input logic [63:0] kmer,
                                               input logic [KMER_LEN-1:0] mask,
                                               input logic [1:0] code);
        logic [63:0] t;
        logic [1:0]  x;
        t = kmer;
        for (int i = 0; i < KMER_LEN; i++) begin
            if (mask[i]) begin
                x = (code != 2'd0) ? code : 2'($urandom_range(3, 1));
                t[2*i +: 2] = t[2*i +: 2] ^ x;
            end
        end
        for (int b = 2 * KMER_LEN; b < 64; b++) t[b] = 1'($urandom_range(1, 0));
        return t;
    endfunction

    function automatic logic [KMER_LEN-1:0] pick_bases(input int count, input int lo,
                                                       input int hi);
        logic [KMER_LEN-1:0] m;
        int                  placed;
        int                  b;
        m = '0;
        placed = 0;
        while (placed < count) begin
            b = $urandom_range(hi, lo);
            if (!m[b]) begin
                m[b] = 1'b1;
                placed++;
            end
        end
        return m;
    endfunction

    // mostly pairs near the filter limits, some arbitrary masks, some pure noise
    function automatic kmer_pair_t random_pair();
        kmer_pair_t          p;
        logic [KMER_LEN-1:0] m;
        int                  shape;
        int                  n_first;
        int                  n_last;
        int                  n_mid;
        int                  room;
        int                  slot;
        shape = $urandom_range(99, 0);
        p.src_kmer = {$urandom, $urandom};
        if (shape < 65) begin
            n_first = $urandom_range(END_MAX + (shape < 6 ? 1 : 0), 0);
            n_last = $urandom_range(END_MAX + (shape >= 59 ? 1 : 0), 0);
            room = TOTAL_MAX + (shape % 7 == 0 ? 1 : 0) - n_first - n_last;
            n_mid = (room > 0) ? $urandom_range(room, 0) : 0;
            if (n_first + n_last + n_mid == 0) n_mid = 1;
            m = pick_bases(n_first, 0, Q1_LO - 1) | pick_bases(n_mid, Q1_LO, Q3_LO - 1)
                | pick_bases(n_last, Q3_LO, KMER_LEN - 1);
            p.tgt_kmer = flip_bases(p.src_kmer, m, 2'd0);
        end else if (shape < 88) begin
            m = pick_bases($urandom_range(KMER_LEN, 0), 0, KMER_LEN - 1);
            p.tgt_kmer = flip_bases(p.src_kmer, m, 2'd0);
        end else begin
            p.tgt_kmer = {$urandom, $urandom};
        end
        p.in_graph = ($urandom_range(11, 0) != 0);
        p.edge_id = $urandom;
        slot = $urandom_range(9, 0);
        if (slot < 6)
            p.offset = {8'h00, $urandom};
        else if (slot < 8)
            p.offset = 40'h00_FFFF_FFFF - 40'($urandom_range(2 * KMER_LEN, 0));
        else
            p.offset = {8'($urandom_range(255, 1)), $urandom};
        return p;
    endfunction

    // returns at the edge where the pair transfer happens
    task automatic send_pair(input kmer_pair_t p);
        start <= 1'b1;
        i_source_kmer <= p.src_kmer;
        i_target_kmer <= p.tgt_kmer;
        i_target_in_graph <= p.in_graph;
        i_edge_id <= p.edge_id;
        i_edge_offset <= p.offset;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_sender(input bit drain);
        int r;
        int gap;
        r = $urandom_range(99, 0);
        if (r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 8);
        if (gap == 0 && !drain) return;
        start <= 1'b0;
        repeat (gap > 0 ? gap : 1) @(posedge i_clk);
        while (drain && pending_candidates.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag_candidate(input string msg);
        bad_candidates++;
        if (bad_candidates <= MAX_REPORTS) $display("%s", msg);
    endtask

    // results are stable mid-cycle, so check them on the falling edge
    always @(negedge i_clk) begin : check_candidates
        candidate_t want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_candidates.size() == 0) begin
                flag_candidate($sformatf("unexpected candidate: edge %h pos %h last %b",
                    o_mismatch_edge, o_mismatch_position, o_last_of_run));
            end else begin
                want = pending_candidates.pop_front();
                if (o_mismatch_edge !== want.edge_id || o_mismatch_position !== want.position
                        || o_last_of_run !== want.last) begin
                    flag_candidate($sformatf(
                        "candidate mismatch: expected edge %h pos %h last %b, got %h %h %b",
                        want.edge_id, want.position, want.last,
                        o_mismatch_edge, o_mismatch_position, o_last_of_run));
                end
            end
        end
    end

    initial begin : drive_pairs
        kmer_pair_t    p;
        candidate_t    c;
        directed_row_t row;
        int            burst_left;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            row = DIRECTED_ROWS[k];
            p.src_kmer = row.src_kmer;
            p.tgt_kmer = flip_bases(row.src_kmer, row.flip_mask, row.flip_code);
            p.in_graph = row.in_graph;
            p.edge_id = row.edge_id;
            p.offset = row.offset;
            send_pair(p);
            if (row.typed) begin
                if (row.typed_hit) begin
                    c.edge_id = row.edge_id;
                    c.position = row.typed_position;
                    c.last = 1'b1;
                    pending_candidates.push_back(c);
                end
            end else begin
                predict_candidates(p);
            end
            idle_sender(k == NUM_DIRECTED - 1);
        end

        // random part opens with a back-to-back stretch
        burst_left = 12;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            p = random_pair();
            send_pair(p);
            predict_candidates(p);
            if (n == NUM_RANDOM - 1) break;
            if ($urandom_range(29, 0) == 0) burst_left = $urandom_range(20, 8);
            if (n == NUM_RANDOM / 2)
                idle_sender(1'b1);
            else if (burst_left > 0)
                burst_left--;
            else
                idle_sender(1'b0);
        end

        start <= 1'b0;
        while (pending_candidates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_candidates == 0)
            $display("PASS kmer_mismatch_candidate_filter");
        else
            $display("FAIL kmer_mismatch_candidate_filter");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("FAIL kmer_mismatch_candidate_filter");
        $finish;
    end

endmodule
